// File: rtl/knps_pkg.sv
package knps_pkg;

    localparam int NEIGHBOR_COUNT_DEF = 5;
    localparam int COORD_BITS_DEF     = 16;
    localparam int ID_BITS_DEF        = 10;

    // stream tuser codes on the input side
    typedef enum logic
    {
        FUNC_START     = 1'b0,
        FUNC_CANDIDATE = 1'b1
    } func_t;

endpackage

// File: rtl/k_nearest_point_select.sv
// results: the tlast word passes the input and list stages, then the output buffer is loaded;
//   then one word per cycle while m_tready is high, up to NEIGHBOR_COUNT words, nearest first
// throughput: one input word per cycle; an input stall occurs only when a query ends at the
//   list stage while the previous query's results are still draining from the output buffer
// reset: asynchronous, clears the pipeline, the query point and id, the kept count and the output count
module k_nearest_point_select #(
    parameter int NEIGHBOR_COUNT = knps_pkg::NEIGHBOR_COUNT_DEF,
    parameter int COORD_BITS     = knps_pkg::COORD_BITS_DEF,
    parameter int ID_BITS        = knps_pkg::ID_BITS_DEF,
    localparam int DIST_BITS     = 2 * COORD_BITS + 1,
    localparam int RANK_BITS     = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1,
    localparam int CNT_BITS      = $clog2(NEIGHBOR_COUNT + 1),
    localparam int IN_BITS       = ID_BITS + 2 * COORD_BITS,
    localparam int IN_DATA_BITS  = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS      = ID_BITS + DIST_BITS + RANK_BITS,
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // point_id, point_x, point_y
    input  logic                     s_tuser,   // func
    input  logic                     s_tlast,   // last_point
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // neighbor_id, distance_sq, rank
    output logic                     m_tlast    // last
);

    localparam int SQ_BITS = 2 * COORD_BITS;

    // input stage
    logic                  s0_valid_reg;
    logic [IN_BITS-1:0]    s0_data_reg;
    logic                  s0_func_reg;
    logic                  s0_last_reg;

    // query point
    logic [COORD_BITS-1:0] query_x_reg;
    logic [COORD_BITS-1:0] query_y_reg;
    logic [ID_BITS-1:0]    query_id_reg;

    // list stage
    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic                  s1_last_reg;
    logic                  s1_excl_reg;
    logic [ID_BITS-1:0]    s1_id_reg;
    logic [SQ_BITS-1:0]    s1_dx2_reg;
    logic [SQ_BITS-1:0]    s1_dy2_reg;

    // sorted neighbor list
    logic [ID_BITS-1:0]    best_id_reg   [NEIGHBOR_COUNT];
    logic [DIST_BITS-1:0]  best_dist_reg [NEIGHBOR_COUNT];
    logic [ID_BITS-1:0]    best_id_next  [NEIGHBOR_COUNT];
    logic [DIST_BITS-1:0]  best_dist_next[NEIGHBOR_COUNT];
    logic [CNT_BITS-1:0]   kept_cnt_reg;
    logic [CNT_BITS-1:0]   kept_cnt_next;
    logic [CNT_BITS-1:0]   ins_cnt;

    // output buffer, head at entry 0
    logic [ID_BITS-1:0]    out_id_reg    [NEIGHBOR_COUNT];
    logic [DIST_BITS-1:0]  out_dist_reg  [NEIGHBOR_COUNT];
    logic [CNT_BITS-1:0]   out_rem_reg;
    logic [RANK_BITS-1:0]  out_rank_reg;

    logic                  s0_take;
    logic                  s1_ready;
    logic                  s1_done;
    logic                  s1_emit;
    logic                  buf_free;
    logic                  out_take;

    logic [ID_BITS-1:0]    s0_id;
    logic [COORD_BITS-1:0] s0_x;
    logic [COORD_BITS-1:0] s0_y;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;

    logic [DIST_BITS-1:0]  cand_dist;
    logic [NEIGHBOR_COUNT-1:0] le;
    logic                  do_insert;

    assign s0_id = s0_data_reg[ID_BITS-1:0];
    assign s0_x  = s0_data_reg[ID_BITS+COORD_BITS-1:ID_BITS];
    assign s0_y  = s0_data_reg[ID_BITS+2*COORD_BITS-1:ID_BITS+COORD_BITS];

    assign dx = (s0_x >= query_x_reg) ? (s0_x - query_x_reg) : (query_x_reg - s0_x);
    assign dy = (s0_y >= query_y_reg) ? (s0_y - query_y_reg) : (query_y_reg - s0_y);

    // handshake and stall chain
    assign out_take = m_tvalid && m_tready;
    assign buf_free = (out_rem_reg == '0) || ((out_rem_reg == CNT_BITS'(1)) && m_tready);
    assign s1_emit  = s1_valid_reg && (s1_func_reg == knps_pkg::FUNC_CANDIDATE) && s1_last_reg;
    assign s1_done  = s1_valid_reg && (!s1_emit || buf_free);
    assign s1_ready = !s1_valid_reg || s1_done;
    assign s0_take  = s0_valid_reg && s1_ready;
    assign s_tready = !s0_valid_reg || s1_ready;

    // insertion into the sorted list
    assign cand_dist = DIST_BITS'(s1_dx2_reg) + DIST_BITS'(s1_dy2_reg);
    assign do_insert = (s1_func_reg == knps_pkg::FUNC_CANDIDATE) && !s1_excl_reg;

    always_comb
    begin
        for (int i = 0; i < NEIGHBOR_COUNT; i++)
        begin
            le[i] = (CNT_BITS'(i) < kept_cnt_reg) && (best_dist_reg[i] <= cand_dist);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NEIGHBOR_COUNT; i++)
        begin
            best_id_next[i]   = best_id_reg[i];
            best_dist_next[i] = best_dist_reg[i];
        end
        ins_cnt = kept_cnt_reg;
        if (do_insert && !le[NEIGHBOR_COUNT-1])
        begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++)
            begin
                if (!le[i])
                begin
                    if (i == 0 || le[(i == 0) ? 0 : i-1])
                    begin
                        best_id_next[i]   = s1_id_reg;
                        best_dist_next[i] = cand_dist;
                    end
                    else
                    begin
                        best_id_next[i]   = best_id_reg[(i == 0) ? 0 : i-1];
                        best_dist_next[i] = best_dist_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
            if (kept_cnt_reg != CNT_BITS'(NEIGHBOR_COUNT))
            begin
                ins_cnt = kept_cnt_reg + CNT_BITS'(1);
            end
        end
        // start word or end of query empties the list
        if (s1_func_reg == knps_pkg::FUNC_START || s1_last_reg)
        begin
            kept_cnt_next = '0;
        end
        else
        begin
            kept_cnt_next = ins_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            query_x_reg  <= '0;
            query_y_reg  <= '0;
            query_id_reg <= '0;
            kept_cnt_reg <= '0;
            out_rem_reg  <= '0;
            out_rank_reg <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                s0_valid_reg <= s_tvalid;
            end
            if (s0_take && s0_func_reg == knps_pkg::FUNC_START)
            begin
                query_x_reg  <= s0_x;
                query_y_reg  <= s0_y;
                query_id_reg <= s0_id;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s1_done)
            begin
                kept_cnt_reg <= kept_cnt_next;
            end
            if (s1_done && s1_emit)
            begin
                out_rem_reg  <= ins_cnt;
                out_rank_reg <= '0;
            end
            else if (out_take)
            begin
                out_rem_reg  <= out_rem_reg - CNT_BITS'(1);
                out_rank_reg <= out_rank_reg + RANK_BITS'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s0_data_reg <= s_tdata[IN_BITS-1:0];
            s0_func_reg <= s_tuser;
            s0_last_reg <= s_tlast;
        end
        if (s0_take)
        begin
            s1_func_reg <= s0_func_reg;
            s1_last_reg <= s0_last_reg;
            s1_excl_reg <= (s0_id == query_id_reg);
            s1_id_reg   <= s0_id;
            s1_dx2_reg  <= SQ_BITS'(dx) * SQ_BITS'(dx);
            s1_dy2_reg  <= SQ_BITS'(dy) * SQ_BITS'(dy);
        end
        if (s1_done)
        begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++)
            begin
                best_id_reg[i]   <= best_id_next[i];
                best_dist_reg[i] <= best_dist_next[i];
            end
        end
        if (s1_done && s1_emit)
        begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++)
            begin
                out_id_reg[i]   <= best_id_next[i];
                out_dist_reg[i] <= best_dist_next[i];
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < NEIGHBOR_COUNT - 1; i++)
            begin
                out_id_reg[i]   <= out_id_reg[i+1];
                out_dist_reg[i] <= out_dist_reg[i+1];
            end
        end
    end

    assign m_tvalid = (out_rem_reg != '0);
    assign m_tlast  = (out_rem_reg == CNT_BITS'(1));
    assign m_tdata  = OUT_DATA_BITS'({out_rank_reg, out_dist_reg[0], out_id_reg[0]});

    // checks
    kept_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        kept_cnt_reg <= CNT_BITS'(NEIGHBOR_COUNT))
        else $error("kept count exceeds list depth");

    out_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_rem_reg <= CNT_BITS'(NEIGHBOR_COUNT))
        else $error("output buffer count exceeds list depth");

    emit_waits_for_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_emit && !buf_free) |=> (s1_valid_reg && s1_emit))
        else $error("query end left the list stage while results were still draining");

    generate
        for (genvar g = 0; g + 1 < NEIGHBOR_COUNT; g++)
        begin : g_sorted
            list_sorted: assert property (@(posedge clk) disable iff (!rst_n)
                (CNT_BITS'(g + 1) < kept_cnt_reg) |-> (best_dist_reg[g] <= best_dist_reg[g+1]))
                else $error("neighbor list out of order");
        end
    endgenerate

endmodule
